// File: design/backslash_escape_decoder_assert.svh
// Assertion macros for the backslash escape decoder.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef BACKSLASH_ESCAPE_DECODER_ASSERT_SVH
`define BACKSLASH_ESCAPE_DECODER_ASSERT_SVH

// same-cycle implication
`define BSED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsed assertion failed");

// next-cycle implication
`define BSED_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsed assertion failed");

`endif

// File: design/bsed_pkg.sv
// Types and character constants for the backslash escape decoder.
// No dependencies.
`default_nettype none

package bsed_pkg;

    localparam int RES_MAX = 3;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_arg;
    } in_req_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_of_run;
    } out_req_t;

    typedef enum logic [5:0] {
        MODE_NORMAL = 6'b000001,
        MODE_BSLASH = 6'b000010,
        MODE_HEX0   = 6'b000100,
        MODE_HEX1   = 6'b001000,
        MODE_OCT    = 6'b010000,
        MODE_SKIP   = 6'b100000
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] pending;
        logic [1:0] digits;
    } dec_state_t;

    // bytes produced by one request, oldest in element 0
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [1:0]              count;
    } dec_out_t;

    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LB   = 8'h62;
    localparam logic [7:0] CH_LE   = 8'h65;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_LN   = 8'h6E;
    localparam logic [7:0] CH_LR   = 8'h72;
    localparam logic [7:0] CH_LT   = 8'h74;
    localparam logic [7:0] CH_LV   = 8'h76;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_ESC = 8'h1B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_HT  = 8'h09;
    localparam logic [7:0] CODE_VT  = 8'h0B;

endpackage

`default_nettype wire

// File: design/bsed_decode.sv
// Single-pass escape decode: current state plus one character gives up to
// three bytes and the next state. Depends on bsed_pkg.
`default_nettype none

module bsed_decode (
    input  wire logic                 esc_en,
    input  wire logic [7:0]           ch,
    input  wire logic                 last,
    input  bsed_pkg::dec_state_t      cur,
    output bsed_pkg::dec_state_t      nxt,
    output bsed_pkg::dec_out_t        res
);

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= bsed_pkg::CH_ZERO && c <= bsed_pkg::CH_NINE) ||
               (c >= bsed_pkg::CH_LA && c <= bsed_pkg::CH_LF) ||
               (c >= bsed_pkg::CH_UA && c <= bsed_pkg::CH_UF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        // letters of either case sit at low nibble 1..6
        return (c > bsed_pkg::CH_NINE) ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

    logic       oct_ch;
    logic       hex_ch;
    logic [3:0] hv;
    logic       to_bslash;
    logic [7:0] oct_acc;

    assign oct_ch    = (ch >= bsed_pkg::CH_ZERO) && (ch <= bsed_pkg::CH_SEVEN);
    assign hex_ch    = is_hex(ch);
    assign hv        = hex_val(ch);
    assign to_bslash = (ch == bsed_pkg::CH_BSL) && !last;
    assign oct_acc   = {cur.pending[4:0], ch[2:0]};

    always_comb
    begin
        nxt       = cur;
        res.bytes = '0;
        res.count = 2'd0;
        if (!esc_en)
        begin
            nxt.mode     = bsed_pkg::MODE_NORMAL;
            nxt.pending  = 8'h00;
            nxt.digits   = 2'd0;
            res.bytes[0] = ch;
            res.count    = 2'd1;
        end
        else
        begin
            unique case (cur.mode)
                bsed_pkg::MODE_BSLASH:
                begin
                    nxt.mode = bsed_pkg::MODE_NORMAL;
                    res.count = 2'd1;
                    unique case (ch)
                        bsed_pkg::CH_LA:  res.bytes[0] = bsed_pkg::CODE_BEL;
                        bsed_pkg::CH_LB:  res.bytes[0] = bsed_pkg::CODE_BS;
                        bsed_pkg::CH_LE:  res.bytes[0] = bsed_pkg::CODE_ESC;
                        bsed_pkg::CH_LF:  res.bytes[0] = bsed_pkg::CODE_FF;
                        bsed_pkg::CH_LN:  res.bytes[0] = bsed_pkg::CODE_LF;
                        bsed_pkg::CH_LR:  res.bytes[0] = bsed_pkg::CODE_CR;
                        bsed_pkg::CH_LT:  res.bytes[0] = bsed_pkg::CODE_HT;
                        bsed_pkg::CH_LV:  res.bytes[0] = bsed_pkg::CODE_VT;
                        bsed_pkg::CH_BSL: res.bytes[0] = bsed_pkg::CH_BSL;
                        bsed_pkg::CH_C:
                        begin
                            nxt.mode  = bsed_pkg::MODE_SKIP;
                            res.count = 2'd0;
                        end
                        bsed_pkg::CH_X:
                        begin
                            if (last)
                            begin
                                res.bytes[0] = bsed_pkg::CH_BSL;
                                res.bytes[1] = bsed_pkg::CH_X;
                                res.count    = 2'd2;
                            end
                            else
                            begin
                                nxt.mode  = bsed_pkg::MODE_HEX0;
                                res.count = 2'd0;
                            end
                        end
                        default:
                        begin
                            if (oct_ch)
                            begin
                                nxt.pending = {5'd0, ch[2:0]};
                                nxt.digits  = (ch == bsed_pkg::CH_ZERO) ? 2'd3 : 2'd2;
                                nxt.mode    = bsed_pkg::MODE_OCT;
                                res.count   = 2'd0;
                            end
                            else
                            begin
                                // unknown escape: backslash then the character
                                res.bytes[0] = bsed_pkg::CH_BSL;
                                res.bytes[1] = ch;
                                res.count    = 2'd2;
                            end
                        end
                    endcase
                end
                bsed_pkg::MODE_HEX0:
                begin
                    if (hex_ch)
                    begin
                        nxt.pending = {4'd0, hv};
                        nxt.mode    = bsed_pkg::MODE_HEX1;
                    end
                    else
                    begin
                        res.bytes[0] = bsed_pkg::CH_BSL;
                        res.bytes[1] = bsed_pkg::CH_X;
                        if (to_bslash)
                        begin
                            nxt.mode  = bsed_pkg::MODE_BSLASH;
                            res.count = 2'd2;
                        end
                        else
                        begin
                            nxt.mode     = bsed_pkg::MODE_NORMAL;
                            res.bytes[2] = ch;
                            res.count    = 2'd3;
                        end
                    end
                end
                bsed_pkg::MODE_HEX1:
                begin
                    nxt.mode = bsed_pkg::MODE_NORMAL;
                    if (hex_ch)
                    begin
                        res.bytes[0] = {cur.pending[3:0], hv};
                        res.count    = 2'd1;
                    end
                    else
                    begin
                        res.bytes[0] = cur.pending;
                        if (to_bslash)
                        begin
                            nxt.mode  = bsed_pkg::MODE_BSLASH;
                            res.count = 2'd1;
                        end
                        else
                        begin
                            res.bytes[1] = ch;
                            res.count    = 2'd2;
                        end
                    end
                end
                bsed_pkg::MODE_OCT:
                begin
                    if (oct_ch && cur.digits != 2'd0)
                    begin
                        nxt.pending = oct_acc;
                        nxt.digits  = cur.digits - 2'd1;
                        if (cur.digits == 2'd1)
                        begin
                            nxt.mode     = bsed_pkg::MODE_NORMAL;
                            res.bytes[0] = oct_acc;
                            res.count    = 2'd1;
                        end
                    end
                    else
                    begin
                        nxt.mode     = bsed_pkg::MODE_NORMAL;
                        nxt.digits   = 2'd0;
                        res.bytes[0] = cur.pending;
                        if (to_bslash)
                        begin
                            nxt.mode  = bsed_pkg::MODE_BSLASH;
                            res.count = 2'd1;
                        end
                        else
                        begin
                            res.bytes[1] = ch;
                            res.count    = 2'd2;
                        end
                    end
                end
                bsed_pkg::MODE_SKIP:
                begin
                    // rest of the argument is dropped
                end
                default:
                begin
                    if (to_bslash)
                    begin
                        nxt.mode = bsed_pkg::MODE_BSLASH;
                    end
                    else
                    begin
                        nxt.mode     = bsed_pkg::MODE_NORMAL;
                        res.bytes[0] = ch;
                        res.count    = 2'd1;
                    end
                end
            endcase

            if (last)
            begin
                // a value still open at end of argument is flushed; every
                // path that leaves one open has produced nothing yet
                if (nxt.mode == bsed_pkg::MODE_HEX1 || nxt.mode == bsed_pkg::MODE_OCT)
                begin
                    res.bytes[0] = nxt.pending;
                    res.count    = 2'd1;
                end
                nxt.mode   = bsed_pkg::MODE_NORMAL;
                nxt.digits = 2'd0;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/bsed_result_buf.sv
// Result register: holds the bytes of one decoded request and hands them
// out one per cycle while dst_stall is low. Depends on bsed_pkg.
`default_nettype none

module bsed_result_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  bsed_pkg::dec_out_t      load_data,
    output logic                    free,
    output logic                    dst_valid,
    input  wire logic               dst_stall,
    output bsed_pkg::out_req_t      dst_req
);

    logic [bsed_pkg::RES_MAX-1:0][7:0] bytes_reg;
    logic [bsed_pkg::RES_MAX-1:0][7:0] bytes_next;
    logic [1:0]                        count_reg;
    logic [1:0]                        count_next;
    logic                              pop;

    assign dst_valid           = (count_reg != 2'd0);
    assign dst_req.byte_out    = bytes_reg[0];
    assign dst_req.last_of_run = (count_reg == 2'd1);
    assign pop                 = dst_valid && !dst_stall;
    assign free                = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);

    always_comb
    begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        if (load)
        begin
            bytes_next = load_data.bytes;
            count_next = load_data.count;
        end
        else if (pop)
        begin
            bytes_next = {8'h00, bytes_reg[2], bytes_reg[1]};
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

`default_nettype wire

// File: design/backslash_escape_decoder.sv
// Backslash escape decoder, top level: input register, decode state and
// result buffer. Depends on bsed_pkg, bsed_decode, bsed_result_buf.
//
// Use: characters of an argument arrive on src (src_valid, src_stall,
// src_req with char_in and end_of_arg). Decoded bytes leave on dst
// (dst_valid, dst_stall, dst_req with byte_out and last_of_run); a request
// is taken on an edge with valid high and stall low. last_of_run marks the
// final byte caused by one character; a character may cause none.
// cfg_we/cfg_wdata write escapes_enabled; write it only while idle.
// Path: a character is held in the input register once accepted, decoded
// from there combinationally, and its bytes are loaded into the result
// register when that is free; dst is driven from the result register.
// Throughput: one character per cycle while each yields at most one byte
// and dst does not stall; a character yielding n bytes holds the result
// register until the one-byte-per-cycle output port has handed out all n.
// Reset clears the decode state to normal, escapes disabled, both stages
// empty. When dst stalls, the result register holds its bytes, the input
// register fills, and src_stall rises once both are full.
`default_nettype none
`include "backslash_escape_decoder_assert.svh"

module backslash_escape_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  bsed_pkg::in_req_t       src_req,
    output logic                    dst_valid,
    input  wire logic               dst_stall,
    output bsed_pkg::out_req_t      dst_req,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata
);

    logic                 esc_reg;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    bsed_pkg::in_req_t    in_req_reg;
    bsed_pkg::dec_state_t state_reg;
    bsed_pkg::dec_state_t state_next;
    bsed_pkg::dec_state_t dec_state;
    bsed_pkg::dec_out_t   dec_res;
    logic                 buf_free;
    logic                 advance;
    logic                 accept;

    bsed_decode u_decode (
        .esc_en (esc_reg),
        .ch     (in_req_reg.char_in),
        .last   (in_req_reg.end_of_arg),
        .cur    (state_reg),
        .nxt    (dec_state),
        .res    (dec_res)
    );

    bsed_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && dec_res.count != 2'd0),
        .load_data (dec_res),
        .free      (buf_free),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_req   (dst_req)
    );

    // requests with no bytes move on even when the result buffer is busy
    assign advance   = in_valid_reg && (buf_free || dec_res.count == 2'd0);
    assign src_stall = in_valid_reg && !advance;
    assign accept    = src_valid && !src_stall;

    always_comb
    begin
        state_next    = advance ? dec_state : state_reg;
        in_valid_next = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg           <= 1'b0;
            in_valid_reg      <= 1'b0;
            state_reg.mode    <= bsed_pkg::MODE_NORMAL;
            state_reg.pending <= 8'h00;
            state_reg.digits  <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                esc_reg <= cfg_wdata;
            end
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg <= src_req;
        end
    end

    `BSED_ASSERT_NXT(a_accept_fills_input, accept, in_valid_reg)
    `BSED_ASSERT_IMP(a_passthru_one_byte, advance && !esc_reg, dec_res.count == 2'd1)
    `BSED_ASSERT_NXT(a_stall_holds_output, dst_valid && dst_stall, dst_valid && $stable(dst_req))
    `BSED_ASSERT_IMP(a_stall_only_when_full, src_stall, in_valid_reg && dst_valid)

endmodule

`default_nettype wire

// File: verif/backslash_escape_decoder_test.sv
// Self-checking testbench for backslash_escape_decoder: directed passthrough and escape
// forms, then random arguments checked byte by byte against an in-bench decoder.
// Depends on bsed_pkg and the backslash_escape_decoder RTL.
module backslash_escape_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               src_valid;
    logic               src_stall;
    bsed_pkg::in_req_t  src_req;
    logic               dst_valid;
    logic               dst_stall;
    bsed_pkg::out_req_t dst_req;
    logic               cfg_we;
    logic               cfg_wdata;

    // decoder state as predicted
    logic            esc_on;
    bsed_pkg::mode_t dec_mode;
    logic [7:0]      dec_pending;
    logic [1:0]      dec_digits;

    bsed_pkg::out_req_t expected_bytes[$];
    logic [7:0]         run_bytes[$];
    logic [7:0]         arg_buf[$];
    int                 mismatch_count;
    logic               idle_on;

    backslash_escape_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_req   (src_req),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_req   (dst_req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= bsed_pkg::CH_ZERO && c <= bsed_pkg::CH_NINE) ||
               (c >= bsed_pkg::CH_LA && c <= bsed_pkg::CH_LF) ||
               (c >= bsed_pkg::CH_UA && c <= bsed_pkg::CH_UF);
    endfunction

    function automatic logic [7:0] hex_val(input logic [7:0] c);
        if (c >= bsed_pkg::CH_LA && c <= bsed_pkg::CH_LF)
            return c - bsed_pkg::CH_LA + 8'd10;
        if (c >= bsed_pkg::CH_UA && c <= bsed_pkg::CH_UF)
            return c - bsed_pkg::CH_UA + 8'd10;
        return c - bsed_pkg::CH_ZERO;
    endfunction

    function automatic void plain_char(input logic [7:0] c, input logic fin);
        if (c == bsed_pkg::CH_BSL && !fin)
            dec_mode = bsed_pkg::MODE_BSLASH;
        else
            run_bytes.push_back(c);
    endfunction

    // advances the decoder by one accepted request and queues the bytes it yields
    function automatic void decode_char(input bsed_pkg::in_req_t req);
        logic [7:0]         c;
        logic               fin;
        bsed_pkg::out_req_t r;
        c   = req.char_in;
        fin = req.end_of_arg;
        run_bytes.delete();
        if (!esc_on)
        begin
            dec_mode    = bsed_pkg::MODE_NORMAL;
            dec_pending = '0;
            dec_digits  = '0;
            run_bytes.push_back(c);
        end
        else
        begin
            case (dec_mode)
                bsed_pkg::MODE_BSLASH:
                begin
                    dec_mode = bsed_pkg::MODE_NORMAL;
                    case (c)
                        bsed_pkg::CH_LA:  run_bytes.push_back(bsed_pkg::CODE_BEL);
                        bsed_pkg::CH_LB:  run_bytes.push_back(bsed_pkg::CODE_BS);
                        bsed_pkg::CH_LE:  run_bytes.push_back(bsed_pkg::CODE_ESC);
                        bsed_pkg::CH_LF:  run_bytes.push_back(bsed_pkg::CODE_FF);
                        bsed_pkg::CH_LN:  run_bytes.push_back(bsed_pkg::CODE_LF);
                        bsed_pkg::CH_LR:  run_bytes.push_back(bsed_pkg::CODE_CR);
                        bsed_pkg::CH_LT:  run_bytes.push_back(bsed_pkg::CODE_HT);
                        bsed_pkg::CH_LV:  run_bytes.push_back(bsed_pkg::CODE_VT);
                        bsed_pkg::CH_BSL: run_bytes.push_back(bsed_pkg::CH_BSL);
                        bsed_pkg::CH_C:   dec_mode = bsed_pkg::MODE_SKIP;
                        bsed_pkg::CH_X:
                        begin
                            if (fin)
                            begin
                                run_bytes.push_back(bsed_pkg::CH_BSL);
                                run_bytes.push_back(bsed_pkg::CH_X);
                            end
                            else
                                dec_mode = bsed_pkg::MODE_HEX0;
                        end
                        default:
                        begin
                            if (c >= bsed_pkg::CH_ZERO && c <= bsed_pkg::CH_SEVEN)
                            begin
                                dec_pending = c - bsed_pkg::CH_ZERO;
                                dec_digits  = (c == bsed_pkg::CH_ZERO) ? 2'd3 : 2'd2;
                                dec_mode    = bsed_pkg::MODE_OCT;
                            end
                            else
                            begin
                                run_bytes.push_back(bsed_pkg::CH_BSL);
                                run_bytes.push_back(c);
                            end
                        end
                    endcase
                end
                bsed_pkg::MODE_HEX0:
                begin
                    if (is_hex(c))
                    begin
                        dec_pending = hex_val(c);
                        dec_mode    = bsed_pkg::MODE_HEX1;
                    end
                    else
                    begin
                        dec_mode = bsed_pkg::MODE_NORMAL;
                        run_bytes.push_back(bsed_pkg::CH_BSL);
                        run_bytes.push_back(bsed_pkg::CH_X);
                        plain_char(c, fin);
                    end
                end
                bsed_pkg::MODE_HEX1:
                begin
                    dec_mode = bsed_pkg::MODE_NORMAL;
                    if (is_hex(c))
                        run_bytes.push_back((dec_pending << 4) + hex_val(c));
                    else
                    begin
                        run_bytes.push_back(dec_pending);
                        plain_char(c, fin);
                    end
                end
                bsed_pkg::MODE_OCT:
                begin
                    if (c >= bsed_pkg::CH_ZERO && c <= bsed_pkg::CH_SEVEN &&
                        dec_digits != 2'd0)
                    begin
                        dec_pending = (dec_pending << 3) + (c - bsed_pkg::CH_ZERO);
                        dec_digits  = dec_digits - 2'd1;
                        if (dec_digits == 2'd0)
                        begin
                            dec_mode = bsed_pkg::MODE_NORMAL;
                            run_bytes.push_back(dec_pending);
                        end
                    end
                    else
                    begin
                        dec_mode   = bsed_pkg::MODE_NORMAL;
                        dec_digits = '0;
                        run_bytes.push_back(dec_pending);
                        plain_char(c, fin);
                    end
                end
                bsed_pkg::MODE_SKIP: ;
                default:
                begin
                    dec_mode = bsed_pkg::MODE_NORMAL;
                    plain_char(c, fin);
                end
            endcase
            if (fin)
            begin
                // a value still being collected is flushed at the end of the argument
                if (dec_mode == bsed_pkg::MODE_HEX1 || dec_mode == bsed_pkg::MODE_OCT)
                    run_bytes.push_back(dec_pending);
                dec_mode   = bsed_pkg::MODE_NORMAL;
                dec_digits = '0;
            end
        end
        foreach (run_bytes[i])
        begin
            r.byte_out    = run_bytes[i];
            r.last_of_run = (i == run_bytes.size() - 1);
            expected_bytes.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance with valid still high
    task automatic send_char(input logic [7:0] c, input logic fin);
        bsed_pkg::in_req_t req;
        req.char_in    = c;
        req.end_of_arg = fin;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        src_req   <= req;
        src_valid <= 1'b1;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        decode_char(req);
        @(negedge clk);
    endtask

    task automatic send_arg();
        foreach (arg_buf[i])
            send_char(arg_buf[i], i == arg_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        arg_buf.delete();
        for (int i = 0; i < s.len(); i++)
            arg_buf.push_back(s[i]);
        send_arg();
    endtask

    // waits out every expected byte plus the pipeline depth, so the block is idle
    task automatic drain();
        src_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_escapes(input logic en);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(negedge clk);
        cfg_we <= 1'b0;
        esc_on = en;
    endtask

    function automatic logic [7:0] rand_hex_digit();
        case ($urandom_range(0, 2))
            0:       return bsed_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            1:       return bsed_pkg::CH_LA + 8'($urandom_range(0, 5));
            default: return bsed_pkg::CH_UA + 8'($urandom_range(0, 5));
        endcase
    endfunction

    // one argument of 1 to 4 escape forms or plain characters, mostly well formed
    task automatic build_arg();
        logic [7:0] letters[9];
        letters = '{bsed_pkg::CH_LA, bsed_pkg::CH_LB, bsed_pkg::CH_LE, bsed_pkg::CH_LF,
                    bsed_pkg::CH_LN, bsed_pkg::CH_LR, bsed_pkg::CH_LT, bsed_pkg::CH_LV,
                    bsed_pkg::CH_BSL};
        arg_buf.delete();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 9))
                0, 1: arg_buf.push_back(8'($urandom_range(1, 255)));
                2:
                begin
                    arg_buf.push_back(bsed_pkg::CH_BSL);
                    arg_buf.push_back(letters[$urandom_range(0, 8)]);
                end
                3:
                begin
                    arg_buf.push_back(bsed_pkg::CH_BSL);
                    arg_buf.push_back(bsed_pkg::CH_X);
                    repeat ($urandom_range(0, 3))
                        arg_buf.push_back(rand_hex_digit());
                end
                4:
                begin
                    arg_buf.push_back(bsed_pkg::CH_BSL);
                    arg_buf.push_back(bsed_pkg::CH_ZERO);
                    repeat ($urandom_range(0, 4))
                        arg_buf.push_back(bsed_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
                end
                5:
                begin
                    arg_buf.push_back(bsed_pkg::CH_BSL);
                    arg_buf.push_back(bsed_pkg::CH_ZERO + 8'($urandom_range(1, 7)));
                    repeat ($urandom_range(0, 3))
                        arg_buf.push_back(bsed_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
                end
                6:
                begin
                    arg_buf.push_back(bsed_pkg::CH_BSL);
                    arg_buf.push_back(bsed_pkg::CH_C);
                end
                7, 8:
                begin
                    arg_buf.push_back(bsed_pkg::CH_BSL);
                    arg_buf.push_back(8'($urandom_range(1, 255)));
                end
                default: arg_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            arg_buf.push_back(bsed_pkg::CH_BSL);
    endtask

    task automatic random_args(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            build_arg();
            sent += arg_buf.size();
            send_arg();
        end
    endtask

    task automatic test_passthrough();
        send_char(8'h01, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(bsed_pkg::CH_BSL, 1'b0);
        send_char(bsed_pkg::CH_LN, 1'b1);
        drain();
        write_escapes(1'b0);
    endtask

    task automatic test_escape_forms();
        write_escapes(1'b1);
        send_text("\\\\");
        send_text("\\q");
        send_text("a\\");
        send_text("\\x");
        send_text("\\xg");
        send_text("\\xFf");
        send_text("\\x7");
        send_text("\\0400");
        send_text("\\1z");
        send_text("\\cab");
        drain();
    endtask

    // turning escapes off drops a value still being collected
    task automatic test_disable_mid_escape();
        send_char(bsed_pkg::CH_BSL, 1'b0);
        send_char(bsed_pkg::CH_X, 1'b0);
        send_char(bsed_pkg::CH_UF, 1'b0);
        drain();
        write_escapes(1'b0);
        send_text("n\\");
        drain();
        write_escapes(1'b1);
    endtask

    task automatic test_random_decode();
        random_args(100);
        drain();
    endtask

    task automatic test_random_passthrough();
        write_escapes(1'b0);
        repeat (30)
            send_char(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
        drain();
        write_escapes(1'b1);
    endtask

    task automatic test_random_steady();
        idle_on = 1'b0;
        random_args(60);
        drain();
    endtask

    initial
    begin
        logic stall_left;
        int   stall_cnt;
        dst_stall = 1'b0;
        stall_cnt = 0;
        forever
        begin
            @(negedge clk);
            if (idle_on && stall_cnt == 0 && $urandom_range(0, 9) == 0)
                stall_cnt = $urandom_range(1, 18);
            stall_left = (idle_on && stall_cnt > 0);
            if (stall_cnt > 0)
                stall_cnt--;
            dst_stall <= stall_left;
        end
    end

    always @(posedge clk)
    begin : check_results
        bsed_pkg::out_req_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("byte %02h with nothing expected", dst_req.byte_out));
            else
            begin
                want = expected_bytes.pop_front();
                if (dst_req.byte_out !== want.byte_out)
                    report_mismatch($sformatf("byte_out %02h, expected %02h",
                                              dst_req.byte_out, want.byte_out));
                if (dst_req.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b on byte %02h",
                                              dst_req.last_of_run, want.last_of_run,
                                              want.byte_out));
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        src_valid      = 1'b0;
        src_req        = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        idle_on        = 1'b1;
        mismatch_count = 0;
        esc_on         = 1'b0;
        dec_mode       = bsed_pkg::MODE_NORMAL;
        dec_pending    = '0;
        dec_digits     = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_passthrough();
        test_escape_forms();
        test_disable_mid_escape();
        test_random_decode();
        test_random_passthrough();
        test_random_steady();

        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/bsed_pkg.sv
design/bsed_decode.sv
design/bsed_result_buf.sv
design/backslash_escape_decoder.sv
verif/backslash_escape_decoder_test.sv
